@@ hdl/sha256_stream_hasher_core_assert.svh @@
// assertion macros used by the hasher controller rtl
`ifndef SHA256_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA256_STREAM_HASHER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SHS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hasher assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SHS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hasher assertion failed");

`endif

@@ hdl/shs_pkg.sv @@
// types, constants and tables of the sha-256 stream hasher
`default_nettype none

package shs_pkg;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  typedef struct packed {
    logic [63:0] data_bytes;
    logic [3:0]  byte_count;
    logic        end_flag;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        final_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_PAD,
    ST_PAD2,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } shs_state_t;

  typedef enum logic [1:0] {
    AFT_DATA,
    AFT_PAD2,
    AFT_OUT
  } shs_after_t;

  typedef struct packed {
    logic       capture;
    logic       absorb;
    logic       pad_first;
    logic       pad_second;
    logic       put_len;
    logic       load_vars;
    logic       round;
    logic       update;
    logic       restart;
    logic [5:0] rnd;
    logic [1:0] word_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic block_full;
    logic pend_last;
    logic fill_late;
  } dp_stat_t;

  function automatic logic [31:0] init_h(input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0:    r = 32'h6a09e667;
      3'd1:    r = 32'hbb67ae85;
      3'd2:    r = 32'h3c6ef372;
      3'd3:    r = 32'ha54ff53a;
      3'd4:    r = 32'h510e527f;
      3'd5:    r = 32'h9b05688c;
      3'd6:    r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] r;
    case (idx)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;  6'd63: r = 32'hc67178f2;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/sha256_stream_hasher_core.sv @@
// top level of the streaming sha-256 hasher
// each input item brings up to eight message bytes (first byte in bits 63..56, byte_count
// above eight counts as eight) and an end flag; the block gathers bytes into a 64-byte
// block window and runs the 64-round compression on one shared round unit, one round per
// clock, whenever the window fills. an item is taken only while the block is idle, so the
// next item waits until the last one is through: intake accepts the item, then writes
// its bytes into the window, and an item that fills the window then adds the load of
// the working variables, 64 rounds and the chain value update, followed by a second
// write pass for any bytes left over. an item with the end flag then pads (0x80, zero
// fill, 64-bit bit length, wrapping modulo 2^64), which takes one or two further
// compressions, and the digest leaves as four 64-bit items, word_index 0 first, final_word
// on the last; after the last one is taken the chain value, fill and length restart for a
// new message.
// rst_n is synchronous, active low; no clearing pass is needed after reset
`default_nettype none

module sha256_stream_hasher_core (
  input  wire                 clk,
  input  wire                 rst_n,
  // message item channel
  input  wire                 in_valid,
  output logic                in_ready,
  input  shs_pkg::in_item_t   in_item,
  // digest item channel
  output logic                out_valid,
  input  wire                 out_ready,
  output shs_pkg::out_item_t  out_item
);
  import shs_pkg::*;

  // commands towards the datapath and status back from it
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing: intake, padding, round count, digest readout
  shs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and arithmetic: window, schedule, round unit, chain value, length
  shs_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

@@ hdl/shs_datapath.sv @@
// datapath: block window, message schedule, round unit, chain value and length
`default_nettype none

module shs_datapath (
  input  wire                  clk,
  input  wire                  rst_n,
  input  shs_pkg::in_item_t    in_item,
  input  shs_pkg::dp_cmd_t     cmd,
  output shs_pkg::dp_stat_t    stat,
  output shs_pkg::out_item_t   out_item
);
  import shs_pkg::*;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // block window doubles as the 16-word schedule shift line
  logic [15:0][31:0] w_r, w_nxt;
  logic [7:0][31:0]  h_r, h_nxt;
  logic [7:0][31:0]  v_r, v_nxt;
  logic [5:0]        fill_r, fill_nxt;
  logic [63:0]       len_r, len_nxt;
  logic [63:0]       pend_data_r, pend_data_nxt;
  logic [3:0]        pend_cnt_r, pend_cnt_nxt;
  logic              pend_last_r, pend_last_nxt;

  logic [3:0]  cnt_sat;
  logic [6:0]  fill_sum;
  logic [6:0]  room;
  logic [3:0]  take;
  logic [31:0] t1, t2, w_new;
  logic [5:0]  off;

  assign cnt_sat  = (in_item.byte_count > 4'd8) ? 4'd8 : in_item.byte_count;
  assign fill_sum = {1'b0, fill_r} + {3'b000, pend_cnt_r};
  assign room     = 7'd64 - {1'b0, fill_r};
  // when the block fills, the room left is at most eight bytes
  assign take     = fill_sum[6] ? room[3:0] : pend_cnt_r;

  assign stat.block_full = fill_sum[6];
  assign stat.pend_last  = pend_last_r;
  assign stat.fill_late  = (fill_r >= LEN_POS);

  assign t1 = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + round_k(cmd.rnd) + w_r[0];
  assign t2 = bsig0(v_r[0])
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign w_new = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];

  // pending item, window fill and length
  always_comb begin
    pend_data_nxt = pend_data_r;
    pend_cnt_nxt  = pend_cnt_r;
    pend_last_nxt = pend_last_r;
    len_nxt       = len_r;
    fill_nxt      = fill_r;
    if (cmd.capture) begin
      pend_data_nxt = in_item.data_bytes;
      pend_cnt_nxt  = cnt_sat;
      pend_last_nxt = in_item.end_flag;
      len_nxt       = len_r + {57'd0, cnt_sat, 3'b000};
    end else if (cmd.absorb) begin
      pend_data_nxt = pend_data_r << {take, 3'b000};
      pend_cnt_nxt  = pend_cnt_r - take;
      fill_nxt      = fill_r + {2'b00, take};
    end else if (cmd.restart) begin
      len_nxt  = 64'd0;
      fill_nxt = 6'd0;
    end
  end

  // block window writes and schedule shift
  always_comb begin
    w_nxt = w_r;
    off   = 6'd0;
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = w_r[i+1];
      end
      w_nxt[15] = w_new;
    end else begin
      for (int p = 0; p < 64; p++) begin
        off = 6'(p) - fill_r;
        if (cmd.absorb && (off < {2'b00, take})) begin
          w_nxt[p>>2][8*(3-(p&3)) +: 8] = pend_data_r[{3'd7 - off[2:0], 3'b000} +: 8];
        end
        if (cmd.pad_first) begin
          if (6'(p) == fill_r) begin
            w_nxt[p>>2][8*(3-(p&3)) +: 8] = PAD_BYTE;
          end else if (6'(p) > fill_r) begin
            w_nxt[p>>2][8*(3-(p&3)) +: 8] = 8'h00;
          end
        end
        if (cmd.pad_second) begin
          w_nxt[p>>2][8*(3-(p&3)) +: 8] = 8'h00;
        end
        if (cmd.put_len && (6'(p) >= LEN_POS)) begin
          w_nxt[p>>2][8*(3-(p&3)) +: 8] = len_r[8*(63-p) +: 8];
        end
      end
    end
  end

  // working variables
  always_comb begin
    v_nxt = v_r;
    if (cmd.load_vars) begin
      v_nxt = h_r;
    end else if (cmd.round) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end
  end

  // chain value
  always_comb begin
    h_nxt = h_r;
    if (cmd.update) begin
      for (int i = 0; i < 8; i++) begin
        h_nxt[i] = h_r[i] + v_r[i];
      end
    end else if (cmd.restart) begin
      for (int i = 0; i < 8; i++) begin
        h_nxt[i] = init_h(3'(i));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= init_h(3'(i));
      end
      fill_r      <= 6'd0;
      len_r       <= 64'd0;
      pend_cnt_r  <= 4'd0;
      pend_last_r <= 1'b0;
    end else begin
      h_r         <= h_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      pend_last_r <= pend_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r         <= w_nxt;
    v_r         <= v_nxt;
    pend_data_r <= pend_data_nxt;
  end

  always_comb begin
    case (cmd.word_idx)
      2'd0:    out_item.digest_word = {h_r[0], h_r[1]};
      2'd1:    out_item.digest_word = {h_r[2], h_r[3]};
      2'd2:    out_item.digest_word = {h_r[4], h_r[5]};
      default: out_item.digest_word = {h_r[6], h_r[7]};
    endcase
    out_item.word_index = cmd.word_idx;
    out_item.final_word = (cmd.word_idx == 2'd3);
  end

endmodule

`default_nettype wire

@@ hdl/shs_ctrl.sv @@
// controller: item intake, padding sequence, round count and digest readout
`default_nettype none

`include "sha256_stream_hasher_core_assert.svh"

module shs_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire                out_ready,
  input  shs_pkg::dp_stat_t  stat,
  output shs_pkg::dp_cmd_t   cmd
);
  import shs_pkg::*;

  shs_state_t state_r, state_nxt;
  shs_after_t after_r, after_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       last_word;

  assign last_word = (idx_r == 2'd3);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_ABSORB;
      end
      ST_ABSORB: begin
        if (stat.block_full)     state_nxt = ST_LOAD;
        else if (stat.pend_last) state_nxt = ST_PAD;
        else                     state_nxt = ST_IDLE;
      end
      ST_PAD:   state_nxt = ST_LOAD;
      ST_PAD2:  state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (rnd_r == 6'd63) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        unique case (after_r)
          AFT_DATA: state_nxt = ST_ABSORB;
          AFT_PAD2: state_nxt = ST_PAD2;
          AFT_OUT:  state_nxt = ST_OUT;
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        if (out_ready && last_word) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd          = '0;
    cmd.rnd      = rnd_r;
    cmd.word_idx = idx_r;
    after_nxt    = after_r;
    rnd_nxt      = rnd_r;
    idx_nxt      = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_ABSORB: begin
        cmd.absorb = 1'b1;
        after_nxt  = AFT_DATA;
      end
      ST_PAD: begin
        cmd.pad_first = 1'b1;
        cmd.put_len   = !stat.fill_late;
        after_nxt     = stat.fill_late ? AFT_PAD2 : AFT_OUT;
      end
      ST_PAD2: begin
        cmd.pad_second = 1'b1;
        cmd.put_len    = 1'b1;
        after_nxt      = AFT_OUT;
      end
      ST_LOAD: begin
        cmd.load_vars = 1'b1;
        rnd_nxt       = 6'd0;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      ST_OUT: begin
        out_valid   = 1'b1;
        cmd.restart = out_ready && last_word;
        if (out_ready) idx_nxt = idx_r + 2'd1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      after_r <= AFT_DATA;
      rnd_r   <= 6'd0;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
    end
  end

  logic [5:0] work_cmds;
  assign work_cmds = {cmd.absorb, cmd.pad_first, cmd.pad_second,
                      cmd.load_vars, cmd.round, cmd.update};

  `SHS_ASSERT_IMP(a_no_overlap, in_ready, !out_valid)
  `SHS_ASSERT_IMP(a_one_step, 1'b1, $onehot0(work_cmds))
  `SHS_ASSERT_NXT(a_round_end, (state_r == ST_ROUND) && (rnd_r == 6'd63), state_r == ST_UPDATE)
  `SHS_ASSERT_NXT(a_back_idle, out_valid && out_ready && last_word, in_ready && (idx_r == 2'd0))

endmodule

`default_nettype wire
